FILE: rtl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

  localparam int DEF_MAX_DIM     = 8;
  localparam int DEF_VALUE_BITS  = 32;
  localparam int DIM_W           = 4;
  localparam int ROW_W           = 3;
  localparam int COL_W           = 3;
  localparam int ELEM_W          = 32;
  localparam int FRAC_BITS       = 16;
  localparam int CMD_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    REQ_WRITE_A  = 2'd0,
    REQ_WRITE_B  = 2'd1,
    REQ_MULTIPLY = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_MUL    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               ok;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [ELEM_W-1:0]  value;
  } cmd_t;

endpackage

FILE: rtl/mme_if.sv
// Request and result channel interfaces of the matrix multiply engine.
`timescale 1ns / 1ps

interface mme_in_if
  import mme_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [ROW_W-1:0]         elem_row;
  logic [COL_W-1:0]         elem_col;
  logic signed [ELEM_W-1:0] elem_value;

  modport source (output valid, req_type, elem_row, elem_col, elem_value, input ready);
  modport sink   (input valid, req_type, elem_row, elem_col, elem_value, output ready);
endinterface

interface mme_out_if
  import mme_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic signed [ELEM_W-1:0] out_value;
  logic                     last;

  modport source (output valid, status, out_row, out_col, out_value, last, input ready);
  modport sink   (input valid, status, out_row, out_col, out_value, last, output ready);
endinterface

FILE: rtl/mme_front.sv
// Front end: accepts requests, range-checks writes and forms queue commands.
`timescale 1ns / 1ps

module mme_front
  import mme_pkg::*;
(
  mme_in_if.sink           in_ch,
  input  logic [DIM_W-1:0] rows_a,
  input  logic [DIM_W-1:0] inner_dim,
  input  logic [DIM_W-1:0] cols_b,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_data
);

  logic             accept;
  logic [DIM_W-1:0] rlim;
  logic [DIM_W-1:0] clim;
  logic             in_range;
  logic             is_cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    rlim       = rows_a;
    clim       = inner_dim;
    is_cmd     = 1'b1;
    q_data     = '0;
    q_data.row = in_ch.elem_row;
    q_data.col = in_ch.elem_col;
    q_data.value = in_ch.elem_value;
    unique case (req_t'(in_ch.req_type))
      REQ_WRITE_A: begin
        q_data.kind = CMD_LOAD_A;
      end
      REQ_WRITE_B: begin
        q_data.kind = CMD_LOAD_B;
        rlim        = inner_dim;
        clim        = cols_b;
      end
      REQ_MULTIPLY: begin
        q_data.kind = CMD_MUL;
      end
      default: begin
        is_cmd = 1'b0;
      end
    endcase
    in_range  = ({1'b0, in_ch.elem_row} < rlim) && ({1'b0, in_ch.elem_col} < clim);
    q_data.ok = in_range;
  end

  // drop unused request codes
  assign q_push = accept && is_cmd;

endmodule

FILE: rtl/mme_cmd_fifo.sv
// Command queue between the front end and the execution back end.
`timescale 1ns / 1ps

module mme_cmd_fifo
  import mme_pkg::*;
#(
  parameter int DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/mme_back.sv
// Back end: element stores, multiply-accumulate pipeline and result register.
`timescale 1ns / 1ps

module mme_back
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIM_W-1:0] rows_a,
  input  logic [DIM_W-1:0] inner_dim,
  input  logic [DIM_W-1:0] cols_b,
  input  logic             q_empty,
  input  cmd_t             q_data,
  output logic             q_pop,
  mme_out_if.source        out_ch
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam logic signed [ACC_W-1:0] VMAX =
    (ACC_W'(1) << (VALUE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] VMIN = -VMAX - ACC_W'(1);
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  typedef struct packed {
    logic             vld;
    logic             is_load;
    logic             status;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tok_t;

  state_t           st_r;
  logic [ROW_W-1:0] i_r;
  logic [COL_W-1:0] j_r;
  logic [ROW_W-1:0] k_r;

  logic [VALUE_BITS-1:0] mem_a [DEPTH];
  logic [VALUE_BITS-1:0] mem_b [DEPTH];
  logic [DEPTH-1:0]      va_r;
  logic [DEPTH-1:0]      vb_r;

  logic                         pipe_en;
  logic                         k_last;
  logic                         j_last;
  logic                         i_last;
  tok_t                         s0;
  tok_t                         s1_r;
  tok_t                         s2_r;
  tok_t                         s3_r;
  logic [ADDR_W-1:0]            waddr;
  logic [ADDR_W-1:0]            raddr_a;
  logic [ADDR_W-1:0]            raddr_b;
  logic [VALUE_BITS-1:0]        wval;
  logic                         we_a;
  logic                         we_b;
  logic signed [VALUE_BITS-1:0] rd_a_r;
  logic signed [VALUE_BITS-1:0] rd_b_r;
  logic                         rdv_a_r;
  logic                         rdv_b_r;
  logic signed [VALUE_BITS-1:0] op_a;
  logic signed [VALUE_BITS-1:0] op_b;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [ACC_W-1:0]      acc_nxt;
  logic signed [ACC_W-1:0]      shifted;
  logic signed [VALUE_BITS-1:0] sat_v;

  logic                     out_valid_r;
  logic                     out_status_r;
  logic [ROW_W-1:0]         out_row_r;
  logic [COL_W-1:0]         out_col_r;
  logic signed [ELEM_W-1:0] out_value_r;
  logic                     out_last_r;

  // stall the whole pipeline while a result waits
  assign pipe_en = !out_valid_r || out_ch.ready;
  assign q_pop   = (st_r == ST_IDLE) && pipe_en && !q_empty;

  assign k_last = ({1'b0, k_r} == inner_dim - DIM_W'(1));
  assign j_last = ({1'b0, j_r} == cols_b - DIM_W'(1));
  assign i_last = ({1'b0, i_r} == rows_a - DIM_W'(1));

  assign waddr   = ADDR_W'(32'(q_data.row) * MAX_DIM + 32'(q_data.col));
  assign raddr_a = ADDR_W'(32'(i_r) * MAX_DIM + 32'(k_r));
  assign raddr_b = ADDR_W'(32'(k_r) * MAX_DIM + 32'(j_r));
  assign wval    = q_data.value[VALUE_BITS-1:0];
  assign we_a    = q_pop && q_data.ok && (q_data.kind == CMD_LOAD_A);
  assign we_b    = q_pop && q_data.ok && (q_data.kind == CMD_LOAD_B);

  always_comb begin
    s0 = '0;
    if (st_r == ST_RUN) begin
      s0.vld       = 1'b1;
      s0.status    = STATUS_OK;
      s0.first     = (k_r == '0);
      s0.last_k    = k_last;
      s0.last_elem = k_last && j_last && i_last;
      s0.row       = i_r;
      s0.col       = j_r;
    end else if (q_pop && (q_data.kind != CMD_MUL)) begin
      s0.vld     = 1'b1;
      s0.is_load = 1'b1;
      s0.status  = q_data.ok ? STATUS_OK : STATUS_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      i_r  <= '0;
      j_r  <= '0;
      k_r  <= '0;
    end else if (pipe_en) begin
      unique case (st_r)
        ST_IDLE: begin
          if (q_pop && (q_data.kind == CMD_MUL)) begin
            st_r <= ST_RUN;
            i_r  <= '0;
            j_r  <= '0;
            k_r  <= '0;
          end
        end
        ST_RUN: begin
          if (!k_last) begin
            k_r <= k_r + ROW_W'(1);
          end else begin
            k_r <= '0;
            if (!j_last) begin
              j_r <= j_r + COL_W'(1);
            end else begin
              j_r <= '0;
              if (i_last) begin
                st_r <= ST_IDLE;
              end else begin
                i_r <= i_r + ROW_W'(1);
              end
            end
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wval;
    end
    if (pipe_en) begin
      rd_a_r <= mem_a[raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wval;
    end
    if (pipe_en) begin
      rd_b_r <= mem_b[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= '0;
      vb_r    <= '0;
      rdv_a_r <= 1'b0;
      rdv_b_r <= 1'b0;
    end else begin
      if (we_a) begin
        va_r[waddr] <= 1'b1;
      end
      if (we_b) begin
        vb_r[waddr] <= 1'b1;
      end
      if (pipe_en) begin
        rdv_a_r <= va_r[raddr_a];
        rdv_b_r <= vb_r[raddr_b];
      end
    end
  end

  assign op_a    = rdv_a_r ? rd_a_r : '0;
  assign op_b    = rdv_b_r ? rd_b_r : '0;
  assign acc_nxt = (s2_r.first ? '0 : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prod_r <= op_a * op_b;
      if (s2_r.vld && !s2_r.is_load) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (pipe_en) begin
      s1_r <= s0;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  assign shifted = acc_r >>> FRAC_BITS;

  always_comb begin
    priority if (shifted > VMAX) begin
      sat_v = VMAX[VALUE_BITS-1:0];
    end else if (shifted < VMIN) begin
      sat_v = VMIN[VALUE_BITS-1:0];
    end else begin
      sat_v = shifted[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= s3_r.vld && (s3_r.is_load || s3_r.last_k);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_status_r <= s3_r.status;
      out_row_r    <= s3_r.row;
      out_col_r    <= s3_r.col;
      out_value_r  <= s3_r.is_load ? '0 : ELEM_W'(sat_v);
      out_last_r   <= s3_r.is_load || s3_r.last_elem;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;

  a_run_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) && pipe_en && s0.last_elem |=> (st_r == ST_IDLE))
    else $error("sequencer did not return to idle after the final element");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(s3_r) && $stable(acc_r))
    else $error("pipeline advanced during an output stall");

  a_last_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && s3_r.vld && !s3_r.is_load && s3_r.last_elem |=> out_valid_r && out_last_r)
    else $error("final product element not emitted with last");

endmodule

FILE: rtl/matrix_multiply_engine_core.sv
// Top level of the matrix multiply engine: configuration registers, front end, queue, back end.
// Writes: each status passes the queue, stages s1, s2, s3 and the result register; loads run
// 1 per cycle while no multiply runs and the output is not stalled. Multiply: the shared MAC unit
// steps through rows_a*cols_b*inner_dim products; one store read pair per cycle, barring stalls, sets the pace.
// Reset: dimensions return to MAX_DIM and both stores read as zero through per-entry valid bits.
`timescale 1ns / 1ps

module matrix_multiply_engine_core
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  mme_in_if.sink      in_ch,
  mme_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  logic [DIM_W-1:0] rows_a_r;
  logic [DIM_W-1:0] inner_dim_r;
  logic [DIM_W-1:0] cols_b_r;
  logic [DIM_W-1:0] wr_dim;
  logic             wr_en;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_out;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    priority if (pwdata[DIM_W-1:0] == '0) begin
      wr_dim = DIM_W'(1);
    end else if (pwdata[DIM_W-1:0] > DIM_W'(MAX_DIM)) begin
      wr_dim = DIM_W'(MAX_DIM);
    end else begin
      wr_dim = pwdata[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(MAX_DIM);
      inner_dim_r <= DIM_W'(MAX_DIM);
      cols_b_r    <= DIM_W'(MAX_DIM);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ROWS_A:    rows_a_r    <= wr_dim;
        REG_INNER_DIM: inner_dim_r <= wr_dim;
        REG_COLS_B:    cols_b_r    <= wr_dim;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A:    prdata = 32'(rows_a_r);
      REG_INNER_DIM: prdata = 32'(inner_dim_r);
      REG_COLS_B:    prdata = 32'(cols_b_r);
      default:       prdata = '0;
    endcase
  end

  mme_front u_front (
    .in_ch     (in_ch),
    .rows_a    (rows_a_r),
    .inner_dim (inner_dim_r),
    .cols_b    (cols_b_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  mme_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  mme_back #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rows_a    (rows_a_r),
    .inner_dim (inner_dim_r),
    .cols_b    (cols_b_r),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule
